// ----- hdl/urtm_pkg.sv -----
// Package: shared constants and types for the ultrasonic range trimmed-mean core.
package urtm_pkg;

  // Build-time defaults
  localparam int SAMPLES_DEF    = 10;
  localparam int COUNT_BITS_DEF = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_TIMEOUT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_TIMEOUT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS      = 2'd3;

  localparam logic [CFG_DATA_W-1:0] TRIGGER_TICKS_RST = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] RISE_TIMEOUT_RST  = 16'd30000;
  localparam logic [CFG_DATA_W-1:0] WIDTH_TIMEOUT_RST = 16'd30000;
  localparam logic [CFG_DATA_W-1:0] GAP_TICKS_RST     = 16'd20000;

  // Phase timer width
  localparam int TICK_W = 16;

  // Millimetre values
  localparam int MM_W = 14;
  localparam logic [MM_W-1:0] MM_MAX = 14'h3FFF;

  // Width clamp: any echo width at or above this saturates to MM_MAX
  localparam int WCLAMP_W = 17;
  localparam logic [WCLAMP_W-1:0] WIDTH_CLAMP = 17'd96377;

  // 17 * width fits in 21 bits after the clamp; divide by 100 by reciprocal
  localparam int MMX_W     = 21;
  localparam int RECIP_W   = 22;
  localparam logic [RECIP_W-1:0] RECIP100 = 22'd2684355;  // ceil(2^28 / 100)
  localparam int RECIP100_SH = 28;
  localparam int MMQ_W     = 15;

  // Per-tick control that travels alongside the data through the pipeline
  typedef struct packed {
    logic trig;   // trigger pin level
    logic busy;   // burst in progress
    logic err;    // sticky timeout flag
    logic fin;    // a ping ended on this tick
    logic last;   // that ping completed the burst
    logic clr;    // burst start: clear the accumulators
  } urtm_side_t;

endpackage

// ----- hdl/ultrasonic_range_trimmed_mean_core.sv -----
// Top level: ultrasonic ranger burst sequencer with trimmed-mean distance.
//
//  channel | ports                                      | direction | handshake
//  --------+--------------------------------------------+-----------+------------------
//  in      | in_echo_level, in_start_request            | to core   | in_valid/in_stall
//  out     | out_trigger_level, out_busy_res,           | from core | out_valid/out_stall
//          | out_done_res, out_distance_mm,             |           |
//          | out_error_seen                             |           |
//  cfg     | cfg_wr_en, cfg_index, cfg_data             | to core   | write enable only
//
// Each request is one microsecond tick; one result leaves for every request.
// A new request is taken in every cycle unless a stall on the output holds it; each
// result leaves through the stage chain: sequencer, scale, divide-by-100 multiply,
// accumulate, trim, divide-by-(SAMPLES-2) multiply into the output register.
// rst_n is synchronous and active low; it clears the sequencer, the accumulators,
// the held distance and all stage valids, and reloads the configuration defaults.
// A stall on a valid output freezes every stage at once and raises in_stall.
module ultrasonic_range_trimmed_mean_core #(
  parameter int SAMPLES    = urtm_pkg::SAMPLES_DEF,
  parameter int COUNT_BITS = urtm_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_echo_level,
  input  logic                            in_start_request,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_trigger_level,
  output logic                            out_busy_res,
  output logic                            out_done_res,
  output logic [urtm_pkg::MM_W-1:0]       out_distance_mm,
  output logic                            out_error_seen,
  // configuration writes
  input  logic                            cfg_wr_en,
  input  logic [urtm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [urtm_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Sample counter holds SAMPLES itself
  localparam int IDX_W = $clog2(SAMPLES + 1);
  // Running sum of SAMPLES millimetre values never wraps
  localparam int SUM_W = $clog2(SAMPLES * 16383 + 1);
  // Width of the clamp compare
  localparam int WEXT_W = (COUNT_BITS > urtm_pkg::WCLAMP_W) ? COUNT_BITS
                                                             : urtm_pkg::WCLAMP_W;
  // Trimmed mean: divide by SAMPLES-2 through an exact reciprocal
  localparam int DIV_D  = SAMPLES - 2;
  localparam int DIV_K  = SUM_W + $clog2(DIV_D);
  localparam longint unsigned DIV_M = ((64'd1 << DIV_K) + 64'(DIV_D) - 64'd1) / 64'(DIV_D);
  localparam int DIVM_W = DIV_K + 1;
  localparam int DPROD_W = DIV_K + urtm_pkg::MM_W;
  localparam int MPROD_W = urtm_pkg::MMX_W + urtm_pkg::RECIP_W;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TRIG,
    PH_RISE,
    PH_HIGH,
    PH_GAP
  } phase_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [urtm_pkg::TICK_W-1:0] trig_ticks_r, rise_to_r, width_to_r, gap_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_ticks_r <= urtm_pkg::TRIGGER_TICKS_RST;
      rise_to_r    <= urtm_pkg::RISE_TIMEOUT_RST;
      width_to_r   <= urtm_pkg::WIDTH_TIMEOUT_RST;
      gap_ticks_r  <= urtm_pkg::GAP_TICKS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        urtm_pkg::CFG_TRIGGER_TICKS: trig_ticks_r <= cfg_data;
        urtm_pkg::CFG_RISE_TIMEOUT:  rise_to_r    <= cfg_data;
        urtm_pkg::CFG_WIDTH_TIMEOUT: width_to_r   <= cfg_data;
        urtm_pkg::CFG_GAP_TICKS:     gap_ticks_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline advance: every stage moves together unless the output is held
  // ---------------------------------------------------------------------------
  logic adv;
  logic accept;
  logic out_valid_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  // ---------------------------------------------------------------------------
  // Stage 1: ping sequencer
  // ---------------------------------------------------------------------------
  phase_t                      phase_r, phase_nxt;
  logic [urtm_pkg::TICK_W-1:0] tick_r, tick_nxt, tick_inc;
  logic [COUNT_BITS-1:0]       ew_r, ew_nxt, ew_inc;
  logic [IDX_W-1:0]            idx_r, idx_nxt, idx_inc;
  logic                        err_r, err_nxt;
  logic                        fin, last, clr;
  logic [COUNT_BITS-1:0]       fin_w;
  urtm_pkg::urtm_side_t        side1;

  assign tick_inc = tick_r + urtm_pkg::TICK_W'(1);
  assign ew_inc   = ew_r + COUNT_BITS'(1);
  assign idx_inc  = idx_r + IDX_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    ew_nxt    = ew_r;
    idx_nxt   = idx_r;
    err_nxt   = err_r;
    fin       = 1'b0;
    last      = 1'b0;
    clr       = 1'b0;
    fin_w     = '0;

    unique case (phase_r)
      PH_TRIG: begin
        if (tick_r >= trig_ticks_r) begin
          phase_nxt = PH_RISE;
          tick_nxt  = '0;
        end else begin
          tick_nxt = tick_inc;
        end
      end
      PH_RISE: begin
        if (in_echo_level) begin
          // rise tick is the first high tick
          phase_nxt = PH_HIGH;
          tick_nxt  = urtm_pkg::TICK_W'(1);
          ew_nxt    = COUNT_BITS'(1);
          if (urtm_pkg::TICK_W'(1) >= width_to_r) begin
            err_nxt = 1'b1;
            fin     = 1'b1;
            fin_w   = COUNT_BITS'(1);
          end
        end else begin
          tick_nxt = tick_inc;
          if (tick_inc >= rise_to_r) begin
            err_nxt = 1'b1;
            fin     = 1'b1;
          end
        end
      end
      PH_HIGH: begin
        if (in_echo_level) begin
          ew_nxt   = ew_inc;
          tick_nxt = tick_inc;
          if (tick_inc >= width_to_r) begin
            err_nxt = 1'b1;
            fin     = 1'b1;
            fin_w   = ew_inc;
          end
        end else begin
          fin   = 1'b1;
          fin_w = ew_r;
        end
      end
      PH_GAP: begin
        if (tick_r >= gap_ticks_r) begin
          phase_nxt = PH_TRIG;
          tick_nxt  = urtm_pkg::TICK_W'(1);
        end else begin
          tick_nxt = tick_inc;
        end
      end
      default: begin
        // idle, and any unused code falls back to idle
        phase_nxt = PH_IDLE;
        if (in_start_request) begin
          phase_nxt = PH_TRIG;
          tick_nxt  = urtm_pkg::TICK_W'(1);
          ew_nxt    = '0;
          idx_nxt   = '0;
          clr       = 1'b1;
        end
      end
    endcase

    // Ping end: count the sample, then gap or close the burst
    if (fin) begin
      idx_nxt  = idx_inc;
      tick_nxt = '0;
      if (idx_inc >= IDX_W'(SAMPLES)) begin
        phase_nxt = PH_IDLE;
        last      = 1'b1;
      end else begin
        phase_nxt = PH_GAP;
      end
    end

    side1.trig = (phase_nxt == PH_TRIG);
    side1.busy = (phase_nxt != PH_IDLE);
    side1.err  = err_nxt;
    side1.fin  = fin;
    side1.last = last;
    side1.clr  = clr;
  end

  logic                  s1_v_r;
  urtm_pkg::urtm_side_t  s1_side_r;
  logic [COUNT_BITS-1:0] s1_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      ew_r    <= '0;
      idx_r   <= '0;
      err_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      ew_r    <= ew_nxt;
      idx_r   <= idx_nxt;
      err_r   <= err_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: clamp the width and scale by 17
  // ---------------------------------------------------------------------------
  logic [WEXT_W-1:0]             w_ext;
  logic [urtm_pkg::WCLAMP_W-1:0] w_clamp;
  logic [urtm_pkg::MMX_W-1:0]    x_nxt;

  assign w_ext   = WEXT_W'(s1_w_r);
  assign w_clamp = (w_ext >= WEXT_W'(urtm_pkg::WIDTH_CLAMP)) ? urtm_pkg::WIDTH_CLAMP
                                                             : w_ext[urtm_pkg::WCLAMP_W-1:0];
  assign x_nxt   = (urtm_pkg::MMX_W'(w_clamp) << 4) + urtm_pkg::MMX_W'(w_clamp);

  logic                       s2_v_r;
  urtm_pkg::urtm_side_t       s2_side_r;
  logic [urtm_pkg::MMX_W-1:0] s2_x_r;

  // ---------------------------------------------------------------------------
  // Stage 3: divide by 100 and saturate to 14 bits
  // ---------------------------------------------------------------------------
  logic [MPROD_W-1:0]          mprod;
  logic [urtm_pkg::MMQ_W-1:0]  mq;
  logic [urtm_pkg::MM_W-1:0]   mm_nxt;

  assign mprod  = MPROD_W'(s2_x_r) * MPROD_W'(urtm_pkg::RECIP100);
  assign mq     = mprod[urtm_pkg::RECIP100_SH +: urtm_pkg::MMQ_W];
  assign mm_nxt = (mq > urtm_pkg::MMQ_W'(urtm_pkg::MM_MAX)) ? urtm_pkg::MM_MAX
                                                            : mq[urtm_pkg::MM_W-1:0];

  logic                      s3_v_r;
  urtm_pkg::urtm_side_t      s3_side_r;
  logic [urtm_pkg::MM_W-1:0] s3_mm_r;

  // ---------------------------------------------------------------------------
  // Stage 4: running sum, smallest and largest sample of the burst
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0]          sum_r;
  logic [urtm_pkg::MM_W-1:0] min_r, max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      min_r <= urtm_pkg::MM_MAX;
      max_r <= '0;
    end else if (adv && s3_v_r) begin
      if (s3_side_r.clr) begin
        sum_r <= '0;
        min_r <= urtm_pkg::MM_MAX;
        max_r <= '0;
      end else if (s3_side_r.fin) begin
        sum_r <= sum_r + SUM_W'(s3_mm_r);
        if (s3_mm_r < min_r) begin
          min_r <= s3_mm_r;
        end
        if (s3_mm_r > max_r) begin
          max_r <= s3_mm_r;
        end
      end
    end
  end

  logic                 s4_v_r;
  urtm_pkg::urtm_side_t s4_side_r;

  // ---------------------------------------------------------------------------
  // Stage 5: drop the extremes
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0] num_nxt;

  assign num_nxt = sum_r - SUM_W'(min_r) - SUM_W'(max_r);

  logic                 s5_v_r;
  urtm_pkg::urtm_side_t s5_side_r;
  logic [SUM_W-1:0]     s5_num_r;

  // ---------------------------------------------------------------------------
  // Stage 6: divide by SAMPLES-2 into the held distance / output register
  // ---------------------------------------------------------------------------
  logic [DPROD_W-1:0]        dprod;
  logic [urtm_pkg::MM_W-1:0] mean_nxt;

  assign dprod    = DPROD_W'(s5_num_r) * DPROD_W'(DIVM_W'(DIV_M));
  assign mean_nxt = dprod[DIV_K +: urtm_pkg::MM_W];

  urtm_pkg::urtm_side_t      o_side_r;
  logic [urtm_pkg::MM_W-1:0] dist_r;

  // Stage valids and the held distance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      dist_r      <= '0;
    end else if (adv) begin
      s1_v_r      <= in_valid;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      s5_v_r      <= s4_v_r;
      out_valid_r <= s5_v_r;
      if (s5_v_r && s5_side_r.last) begin
        dist_r <= mean_nxt;
      end
    end
  end

  // Stage payloads: advance with the pipeline, no reset needed
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side_r <= side1;
      s1_w_r    <= fin_w;
      s2_side_r <= s1_side_r;
      s2_x_r    <= x_nxt;
      s3_side_r <= s2_side_r;
      s3_mm_r   <= mm_nxt;
      s4_side_r <= s3_side_r;
      s5_side_r <= s4_side_r;
      s5_num_r  <= num_nxt;
      o_side_r  <= s5_side_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Result channel
  // ---------------------------------------------------------------------------
  assign out_valid         = out_valid_r;
  assign out_trigger_level = o_side_r.trig;
  assign out_busy_res      = o_side_r.busy;
  assign out_done_res      = o_side_r.last;
  assign out_error_seen    = o_side_r.err;
  assign out_distance_mm   = dist_r;

endmodule

// ----- test/tb_ultrasonic_range_trimmed_mean_core.sv -----
// Self-checking testbench for the ultrasonic ranger burst core with trimmed-mean output.
`timescale 1ns / 1ps

module tb_ultrasonic_range_trimmed_mean_core;

  localparam int NUM_PINGS = urtm_pkg::SAMPLES_DEF;
  localparam int CNT_W     = urtm_pkg::COUNT_BITS_DEF;
  localparam int MAX_NOTES = 30;    // cap on printed mismatches
  localparam int NUM_ITEMS = 850;   // requests queued over the whole run

  typedef enum logic [2:0] {PH_IDLE, PH_TRIG, PH_RISE, PH_HIGH, PH_GAP} ping_phase_t;

  typedef struct packed {
    logic [urtm_pkg::CFG_DATA_W-1:0] trig_len;
    logic [urtm_pkg::CFG_DATA_W-1:0] rise_limit;
    logic [urtm_pkg::CFG_DATA_W-1:0] high_limit;
    logic [urtm_pkg::CFG_DATA_W-1:0] gap_len;
  } timing_t;

  // Ranger state plus its own copy of the timing registers
  typedef struct packed {
    timing_t                     cfg;
    ping_phase_t                 phase;
    logic [urtm_pkg::TICK_W-1:0] ticks;
    logic [CNT_W-1:0]            width;
    logic [5:0]                  pings;
    logic [19:0]                 mm_total;
    logic [urtm_pkg::MM_W-1:0]   mm_lo;
    logic [urtm_pkg::MM_W-1:0]   mm_hi;
    logic [urtm_pkg::MM_W-1:0]   distance;
    logic                        err;
  } ranger_t;

  typedef struct packed {
    logic echo;
    logic start;
  } tick_req_t;

  typedef struct packed {
    logic                      trig;
    logic                      busy;
    logic                      done;
    logic [urtm_pkg::MM_W-1:0] range_mm;
    logic                      err;
  } tick_result_t;

  logic                            clk              = 1'b0;
  logic                            rst_n            = 1'b0;
  logic                            in_valid         = 1'b0;
  logic                            in_stall;
  logic                            in_echo_level    = 1'b0;
  logic                            in_start_request = 1'b0;
  logic                            out_valid;
  logic                            out_stall        = 1'b0;
  logic                            out_trigger_level;
  logic                            out_busy_res;
  logic                            out_done_res;
  logic [urtm_pkg::MM_W-1:0]       out_distance_mm;
  logic                            out_error_seen;
  logic                            cfg_wr_en        = 1'b0;
  logic [urtm_pkg::CFG_IDX_W-1:0]  cfg_index        = urtm_pkg::CFG_TRIGGER_TICKS;
  logic [urtm_pkg::CFG_DATA_W-1:0] cfg_data         = '0;

  ultrasonic_range_trimmed_mean_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_echo_level     (in_echo_level),
    .in_start_request  (in_start_request),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_trigger_level (out_trigger_level),
    .out_busy_res      (out_busy_res),
    .out_done_res      (out_done_res),
    .out_distance_mm   (out_distance_mm),
    .out_error_seen    (out_error_seen),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #4 clk = ~clk;

  // model tracks requests the core has taken; plan runs ahead to shape the echo
  ranger_t      model;
  ranger_t      plan;
  tick_req_t    pending_ticks[$];
  tick_result_t expected_ticks[$];
  int           errors = 0;

  // Echo shaping knobs for the request generator
  int   rise_wait = 0;
  int   high_left = 0;
  int   width_lo  = 0;
  int   width_hi  = 24;
  logic noisy     = 1'b1;
  int   planned_items  = 0;
  int   planned_bursts = 0;

  // Idle lengths: mostly short, a few long, with calm stretches of none at all
  int calm_left[2] = '{0, 0};
  int send_wait    = 0;
  int hold_left    = 0;

  function automatic int idle_len(input int side);
    int r;
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      calm_left[side] = $urandom_range(10, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic ranger_t ranger_reset();
    ranger_t r;
    r                = '0;
    r.cfg.trig_len   = urtm_pkg::TRIGGER_TICKS_RST;
    r.cfg.rise_limit = urtm_pkg::RISE_TIMEOUT_RST;
    r.cfg.high_limit = urtm_pkg::WIDTH_TIMEOUT_RST;
    r.cfg.gap_len    = urtm_pkg::GAP_TICKS_RST;
    r.phase          = PH_IDLE;
    r.mm_lo          = urtm_pkg::MM_MAX;
    return r;
  endfunction

  // Fold one echo width into the burst; return 1 when the last ping is in.
  function automatic logic log_sample(inout ranger_t r, input logic [CNT_W-1:0] w);
    int unsigned mm;
    int unsigned kept;
    mm = (32'(w) * 32'd17) / 32'd100;
    if (mm > 32'(urtm_pkg::MM_MAX)) mm = 32'(urtm_pkg::MM_MAX);
    r.mm_total = r.mm_total + 20'(mm);
    if (mm < 32'(r.mm_lo)) r.mm_lo = mm[urtm_pkg::MM_W-1:0];
    if (mm > 32'(r.mm_hi)) r.mm_hi = mm[urtm_pkg::MM_W-1:0];
    r.pings = r.pings + 6'd1;
    r.ticks = '0;
    if (r.pings >= NUM_PINGS) begin
      // drop the smallest and largest, floor the mean of the rest
      kept       = (32'(r.mm_total) - 32'(r.mm_lo) - 32'(r.mm_hi)) / 32'(NUM_PINGS - 2);
      r.distance = kept[urtm_pkg::MM_W-1:0];
      r.phase    = PH_IDLE;
      return 1'b1;
    end
    r.phase = PH_GAP;
    return 1'b0;
  endfunction

  // Count one echo-high tick; end the ping when the width limit is reached.
  function automatic logic count_high(inout ranger_t r);
    r.width = r.width + CNT_W'(1);
    r.ticks = r.ticks + urtm_pkg::TICK_W'(1);
    if (r.ticks >= r.cfg.high_limit) begin
      r.err = 1'b1;
      return log_sample(r, r.width);
    end
    return 1'b0;
  endfunction

  // Advance the ranger by one microsecond tick and return what the core reports.
  function automatic tick_result_t ranger_tick(inout ranger_t r, input logic echo,
                                               input logic start);
    tick_result_t res;
    logic         fin;
    fin = 1'b0;
    case (r.phase)
      PH_TRIG: begin
        if (r.ticks >= r.cfg.trig_len) begin
          r.phase = PH_RISE;
          r.ticks = '0;
        end else begin
          r.ticks = r.ticks + urtm_pkg::TICK_W'(1);
        end
      end
      PH_RISE: begin
        if (echo) begin
          // the rise tick is the first high tick
          r.phase = PH_HIGH;
          r.ticks = '0;
          r.width = '0;
          fin     = count_high(r);
        end else begin
          r.ticks = r.ticks + urtm_pkg::TICK_W'(1);
          if (r.ticks >= r.cfg.rise_limit) begin
            r.err = 1'b1;
            fin   = log_sample(r, '0);
          end
        end
      end
      PH_HIGH: begin
        if (echo) begin
          fin = count_high(r);
        end else begin
          fin = log_sample(r, r.width);
        end
      end
      PH_GAP: begin
        if (r.ticks >= r.cfg.gap_len) begin
          r.phase = PH_TRIG;
          r.ticks = urtm_pkg::TICK_W'(1);
        end else begin
          r.ticks = r.ticks + urtm_pkg::TICK_W'(1);
        end
      end
      default: begin
        // idle: a start request opens a burst and clears the accumulators
        r.phase = PH_IDLE;
        if (start) begin
          r.phase    = PH_TRIG;
          r.ticks    = urtm_pkg::TICK_W'(1);
          r.width    = '0;
          r.pings    = '0;
          r.mm_total = '0;
          r.mm_lo    = urtm_pkg::MM_MAX;
          r.mm_hi    = '0;
        end
      end
    endcase
    res.trig     = (r.phase == PH_TRIG);
    res.busy     = (r.phase != PH_IDLE);
    res.done     = fin;
    res.range_mm = r.distance;
    res.err      = r.err;
    return res;
  endfunction

  // Queue one request and pick echo timing whenever the planned ping enters its rise or high phase.
  task automatic queue_tick(input logic echo, input logic start);
    ping_phase_t  was;
    tick_result_t res;
    tick_req_t    req;
    int           lim;
    was = plan.phase;
    res = ranger_tick(plan, echo, start);
    if (res.done) planned_bursts++;
    if (plan.phase == PH_RISE && was != PH_RISE) begin
      lim = plan.cfg.rise_limit;
      if (lim <= 64 && $urandom_range(0, 7) == 0) rise_wait = lim + 1;
      else rise_wait = $urandom_range(0, lim < 6 ? lim : 6);
    end
    if (plan.phase == PH_HIGH && was != PH_HIGH) begin
      lim = plan.cfg.high_limit;
      if (lim <= 64 && $urandom_range(0, 7) == 0) high_left = lim + 2;
      else if (lim < width_lo) high_left = $urandom_range(0, lim);
      else high_left = $urandom_range(width_lo, lim < width_hi ? lim : width_hi);
    end
    req.echo  = echo;
    req.start = start;
    pending_ticks.push_back(req);
    planned_items++;
  endtask

  // Well-formed pings with random timing, a little echo noise on top.
  task automatic plan_ticks(input int n);
    logic echo;
    logic start;
    repeat (n) begin
      start = ($urandom_range(0, 3) == 0);
      echo  = 1'b0;
      case (plan.phase)
        PH_IDLE: begin
          start = ($urandom_range(0, 3) != 0);
          echo  = 1'($urandom_range(0, 1));
        end
        PH_RISE: begin
          echo = (rise_wait == 0);
          if (rise_wait > 0) rise_wait--;
        end
        PH_HIGH: begin
          echo = (high_left > 0);
          if (high_left > 0) high_left--;
        end
        default: ;
      endcase
      if (noisy && $urandom_range(0, 15) == 0) echo = ~echo;
      queue_tick(echo, start);
    end
  endtask

  task automatic wait_drained();
    while (pending_ticks.size() != 0 || in_valid || expected_ticks.size() != 0)
      @(posedge clk);
  endtask

  task automatic cfg_write(input logic [urtm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [urtm_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  // Hold requests until the pipeline is empty, then load all four timing registers.
  task automatic write_timing(input timing_t t);
    wait_drained();
    repeat (8) @(posedge clk);
    cfg_write(urtm_pkg::CFG_TRIGGER_TICKS, t.trig_len);
    cfg_write(urtm_pkg::CFG_RISE_TIMEOUT, t.rise_limit);
    cfg_write(urtm_pkg::CFG_WIDTH_TIMEOUT, t.high_limit);
    cfg_write(urtm_pkg::CFG_GAP_TICKS, t.gap_len);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    model.cfg = t;
    plan.cfg  = t;
  endtask

  // Request driver: predict on every accepted tick, then present the next one.
  always @(posedge clk) begin
    tick_req_t    req;
    tick_result_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        res = ranger_tick(model, in_echo_level, in_start_request);
        expected_ticks.push_back(res);
      end
      // hold the payload while stalled
      if (!in_valid || !in_stall) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          req = pending_ticks.pop_front();
          in_valid         <= 1'b1;
          in_echo_level    <= req.echo;
          in_start_request <= req.start;
          send_wait = idle_len(0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      if (errors < MAX_NOTES) $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Result monitor: compare each taken result with the oldest prediction.
  always @(posedge clk) begin
    tick_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_ticks.size() == 0) begin
          if (errors < MAX_NOTES) $error("result with no request outstanding");
          errors++;
        end else begin
          want = expected_ticks.pop_front();
          check_field("trigger_level", want.trig, out_trigger_level);
          check_field("busy_res", want.busy, out_busy_res);
          check_field("done_res", want.done, out_done_res);
          check_field("distance_mm", want.range_mm, out_distance_mm);
          check_field("error_seen", want.err, out_error_seen);
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) hold_left = idle_len(1);
      end
    end
  end

  initial begin
    timing_t t;
    int      i;
    int      kind;
    int      n;
    int      long_from;
    model = ranger_reset();
    plan  = model;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset timing: idle ticks with the echo toggling, then a start that parks the
    // burst in its 1000-tick trigger while further starts are ignored.
    for (i = 0; i < 16; i++) queue_tick(i[0], i >= 5);

    // All-zero timing: zero trigger acts as one tick, both timeouts fire at once,
    // no gap. Start stays high, so it lands on busy ticks and on the done tick.
    t = '0;
    write_timing(t);
    for (i = 0; i < 36; i++) queue_tick((i % 3) == 2 || (i % 7) == 0, 1'b1);
    while (plan.phase != PH_IDLE) plan_ticks(1);

    // One clean burst of longer echoes under relaxed timeouts.
    noisy        = 1'b0;
    width_lo     = 20;
    width_hi     = 40;
    t.trig_len   = 1;
    t.rise_limit = '1;
    t.high_limit = '1;
    t.gap_len    = '0;
    write_timing(t);
    long_from = planned_bursts;
    while (planned_bursts == long_from) plan_ticks(1);

    // Random phases, each under fresh timing; extremes show up now and then.
    while (planned_items < NUM_ITEMS) begin
      kind     = $urandom_range(0, 9);
      noisy    = 1'b1;
      width_lo = 0;
      width_hi = 24;
      if (kind == 0) begin
        t = '1;
        n = 30;
      end else if (kind == 1) begin
        t.trig_len   = urtm_pkg::CFG_DATA_W'($urandom_range(0, 3));
        t.rise_limit = '1;
        t.high_limit = '1;
        t.gap_len    = urtm_pkg::CFG_DATA_W'($urandom_range(0, 3));
        width_hi     = 200;
        n            = $urandom_range(150, 400);
      end else begin
        t.trig_len   = urtm_pkg::CFG_DATA_W'($urandom_range(0, 4));
        t.rise_limit = urtm_pkg::CFG_DATA_W'($urandom_range(0, 10));
        t.high_limit = urtm_pkg::CFG_DATA_W'($urandom_range(0, 24));
        t.gap_len    = urtm_pkg::CFG_DATA_W'($urandom_range(0, 5));
        n            = $urandom_range(60, 200);
      end
      if (n > NUM_ITEMS - planned_items) n = NUM_ITEMS - planned_items;
      write_timing(t);
      plan_ticks(n);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #100_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- ultrasonic_range_trimmed_mean_core.f -----
hdl/urtm_pkg.sv
hdl/ultrasonic_range_trimmed_mean_core.sv
test/tb_ultrasonic_range_trimmed_mean_core.sv
